// ===== rtl/core/eerld_pkg.sv =====
// ----------------------------------------------------------------------------
// Electron event run-length decoder package
// Shared types, field widths and code constants for the run-length decoder
// and its checker.
// ----------------------------------------------------------------------------
package eerld_pkg;

  // Sensor geometry: the frame is a square of 2^SIDE_BITS pixels a side.
  localparam int unsigned SIDE_BITS = 12;
  localparam int unsigned PIX_W     = 2 * SIDE_BITS + 1;
  localparam logic [PIX_W-1:0] PIX_TOTAL = PIX_W'(1) << (2 * SIDE_BITS);

  // Bit buffer and its fill count.
  localparam int unsigned BUF_W = 20;
  localparam int unsigned CNT_W = 5;

  // Run and symbol code widths.
  localparam int unsigned RUN7_W = 7;
  localparam int unsigned RUN8_W = 8;
  localparam int unsigned SYM_W  = 4;

  // Output coordinate width.
  localparam int unsigned COORD_W = 14;

  // Code constants.
  localparam logic [SYM_W-1:0]  SYM_FLIP = 4'hA;
  localparam logic [RUN7_W-1:0] SKIP7    = 7'd127;
  localparam logic [RUN8_W-1:0] SKIP8    = 8'd255;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SEVEN_BIT_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_UPSAMPLING     = 1'b1;

  // Upsampling codes; any other value means the native grid.
  localparam logic [1:0] UPS_X2 = 2'd2;
  localparam logic [1:0] UPS_X4 = 2'd3;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_EVENT = 2'd0,
    KIND_OK    = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  // One input transaction.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_first;
    logic       frame_final;
  } in_item_t;

  // One output transaction.
  typedef struct packed {
    kind_e              kind;
    logic [COORD_W-1:0] coord_x;
    logic [COORD_W-1:0] coord_y;
    logic               last;
  } out_item_t;

  // Decoder working state.
  typedef struct packed {
    logic [BUF_W-1:0] bit_buf;
    logic [CNT_W-1:0] bit_cnt;
    logic [PIX_W-1:0] pix;
  } dec_state_t;

  // Outcome of one decode step.
  typedef struct packed {
    dec_state_t st;
    logic       res_valid;
    out_item_t  res;
    logic       done;
    logic       go;
  } step_out_t;

endpackage

// ===== rtl/core/electron_event_run_length_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// Electron event run-length decoder
// Decodes a compressed electron-event frame, one byte per transaction, into
// electron coordinates, optionally upsampled, and a frame status.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one compressed byte per transaction, with
//   frame_first on the first byte of a frame and frame_final on its last.
//   The output channel carries electron events and one status per frame
//   (ok, or pixel count error); last marks the final result of a byte.
//   Each byte is decoded in the cycle it is accepted; its results appear on
//   the output in the next cycle, one per cycle unless the receiver stalls.
//   A byte yields at most two results, and the output holding register has
//   two entries: the block takes one byte per cycle while bytes give at most
//   one result each, and a byte with two holds the input until one has left.
//   While the receiver stalls, results wait in the holding register and the
//   input stalls once a new byte could not be stored.
//   Reset clears the bit buffer, pixel counter and frame status, selects
//   8-bit run codes and the native grid, and empties the output.
//   Configuration is written through cfg_we_i, cfg_idx_i and cfg_data_i.
// ----------------------------------------------------------------------------
module electron_event_run_length_decoder_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [eerld_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [eerld_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  eerld_pkg::in_item_t                 in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output eerld_pkg::out_item_t                out_data_o
);
  import eerld_pkg::*;

  // One decode step: a run code, an optional symbol and the pixel checks.
  function automatic step_out_t decode_step(dec_state_t st, logic active,
                                            logic seven, logic [1:0] ups);
    logic [CNT_W-1:0]     rb;
    logic [CNT_W-1:0]     cw;
    logic [RUN8_W-1:0]    p;
    logic [PIX_W-1:0]     target;
    logic [SYM_W-1:0]     sym;
    logic [SIDE_BITS-1:0] px;
    logic [SIDE_BITS-1:0] py;
    step_out_t            r;
    r           = '0;
    r.st        = st;
    r.res.kind  = KIND_EVENT;
    rb     = seven ? CNT_W'(RUN7_W) : CNT_W'(RUN8_W);
    cw     = rb + CNT_W'(SYM_W);
    p      = seven ? {1'b0, st.bit_buf[RUN7_W-1:0]} : st.bit_buf[RUN8_W-1:0];
    target = st.pix + PIX_W'(p);
    sym    = (seven ? st.bit_buf[RUN7_W+SYM_W-1:RUN7_W]
                    : st.bit_buf[RUN8_W+SYM_W-1:RUN8_W]) ^ SYM_FLIP;
    px     = target[SIDE_BITS-1:0];
    py     = target[2*SIDE_BITS-1:SIDE_BITS];
    if (active && (st.bit_cnt >= rb)) begin
      if (target == PIX_TOTAL) begin
        // Exact end of frame: ok status without waiting for the symbol.
        r.res_valid  = 1'b1;
        r.res.kind   = KIND_OK;
        r.st.bit_buf = '0;
        r.st.bit_cnt = '0;
        r.st.pix     = target;
        r.done       = 1'b1;
      end else if (target > PIX_TOTAL) begin
        // Run overshoots the frame.
        r.res_valid  = 1'b1;
        r.res.kind   = KIND_ERROR;
        r.st.bit_buf = '0;
        r.st.bit_cnt = '0;
        r.done       = 1'b1;
      end else if (seven && (p[RUN7_W-1:0] == SKIP7)) begin
        // Bare 7-bit skip code.
        r.st.bit_buf = st.bit_buf >> RUN7_W;
        r.st.bit_cnt = st.bit_cnt - CNT_W'(RUN7_W);
        r.st.pix     = target;
        r.go         = 1'b1;
      end else if (st.bit_cnt >= cw) begin
        r.st.bit_buf = seven ? (st.bit_buf >> (RUN7_W + SYM_W))
                             : (st.bit_buf >> (RUN8_W + SYM_W));
        r.st.bit_cnt = st.bit_cnt - cw;
        r.go         = 1'b1;
        if (!seven && (p == SKIP8)) begin
          r.st.pix = target;
        end else begin
          r.res_valid = 1'b1;
          r.st.pix    = target + PIX_W'(1);
          case (ups)
            UPS_X4: begin
              r.res.coord_x = (COORD_W'(px) << 2) | COORD_W'(sym[1:0]);
              r.res.coord_y = (COORD_W'(py) << 2) | COORD_W'(sym[3:2]);
            end
            UPS_X2: begin
              r.res.coord_x = (COORD_W'(px) << 1) | COORD_W'(sym[1]);
              r.res.coord_y = (COORD_W'(py) << 1) | COORD_W'(sym[3]);
            end
            default: begin
              r.res.coord_x = COORD_W'(px);
              r.res.coord_y = COORD_W'(py);
            end
          endcase
        end
      end
    end
    return r;
  endfunction

  // Configuration and decoder state.
  logic       seven_q;
  logic [1:0] ups_q;
  dec_state_t state_q, state_d;
  logic       done_q, done_d;

  // Output holding register.
  out_item_t  hold_q [2];
  out_item_t  hold_d [2];
  logic [1:0] ocnt_q, ocnt_d;

  logic       acc;
  logic       pop;
  dec_state_t st_clr;
  dec_state_t st_in;
  logic       done_clr;
  step_out_t  s1, s2;
  logic       done_a;
  logic       fin;
  out_item_t  fin_res;
  out_item_t  slot0, slot1;
  logic [1:0] n_res;

  // Handshake: accept only when the holding register is empty or its one entry leaves this cycle.
  assign pop        = (ocnt_q != 2'd0) && !out_stall_i;
  assign in_stall_o = !((ocnt_q == 2'd0) || ((ocnt_q == 2'd1) && pop));
  assign acc        = in_valid_i && !in_stall_o;
  assign out_valid_o = (ocnt_q != 2'd0);
  assign out_data_o  = hold_q[0];

  // Decode of one byte: frame start, bit merge, two steps and the frame end.
  always_comb begin
    st_clr   = state_q;
    done_clr = done_q;
    if (in_data_i.frame_first) begin
      st_clr   = '0;
      done_clr = 1'b0;
    end
    st_in         = st_clr;
    st_in.bit_buf = st_clr.bit_buf | (BUF_W'(in_data_i.data_byte) << st_clr.bit_cnt);
    st_in.bit_cnt = st_clr.bit_cnt + CNT_W'(8);

    s1 = decode_step(st_in, !done_clr, seven_q, ups_q);
    s2 = decode_step(s1.st, s1.go, seven_q, ups_q);
    done_a = s1.done || s2.done;

    fin          = in_data_i.frame_final && !done_clr && !done_a &&
                   !(s1.res_valid && s2.res_valid);
    fin_res      = '0;
    fin_res.kind = KIND_ERROR;

    // Next decoder state.
    if (done_clr) begin
      state_d = st_clr;
      done_d  = 1'b1;
    end else if (fin) begin
      state_d         = s2.st;
      state_d.bit_buf = '0;
      state_d.bit_cnt = '0;
      done_d          = 1'b1;
    end else begin
      state_d = s2.st;
      done_d  = done_a;
    end

    // Pack the results in order.
    slot1 = fin_res;
    if (s1.res_valid) begin
      slot0 = s1.res;
      if (s2.res_valid) begin
        slot1 = s2.res;
      end
    end else if (s2.res_valid) begin
      slot0 = s2.res;
    end else begin
      slot0 = fin_res;
    end
    n_res = 2'(s1.res_valid) + 2'(s2.res_valid) + 2'(fin);
    if (n_res == 2'd1) begin
      slot0.last = 1'b1;
    end
    if (n_res == 2'd2) begin
      slot1.last = 1'b1;
    end
  end

  // Holding register update.
  always_comb begin
    hold_d = hold_q;
    ocnt_d = ocnt_q;
    if (acc) begin
      hold_d[0] = slot0;
      hold_d[1] = slot1;
      ocnt_d    = n_res;
    end else if (pop) begin
      hold_d[0] = hold_q[1];
      ocnt_d    = ocnt_q - 2'd1;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seven_q <= 1'b0;
      ups_q   <= 2'd1;
      state_q <= '0;
      done_q  <= 1'b0;
      ocnt_q  <= 2'd0;
    end else begin
      if (cfg_we_i && (cfg_idx_i == CFG_SEVEN_BIT_MODE)) begin
        seven_q <= cfg_data_i[0];
      end
      if (cfg_we_i && (cfg_idx_i == CFG_UPSAMPLING)) begin
        ups_q <= cfg_data_i;
      end
      if (acc) begin
        state_q <= state_d;
        done_q  <= done_d;
      end
      ocnt_q <= ocnt_d;
    end
  end

  // Result payload registers.
  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
  end

endmodule

// ===== rtl/core/eerld_checker.sv =====
// ----------------------------------------------------------------------------
// Electron event run-length decoder checker
// Port-level assertions on the decoder's output sequencing and flow control.
// ----------------------------------------------------------------------------
module eerld_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input eerld_pkg::out_item_t out_data_o
);
  import eerld_pkg::*;

  // A stalled output transaction holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output transaction changed");

  // Status results carry no coordinates.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.kind != KIND_EVENT) |->
      (out_data_o.coord_x == '0) && (out_data_o.coord_y == '0))
    else $error("status result with nonzero coordinates");

  // The second result of a byte follows right after the first.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_data_o.last |=> out_valid_o)
    else $error("second result of a byte did not follow");

  // With nothing pending on the output, the input is never stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

endmodule

bind electron_event_run_length_decoder_unit eerld_checker u_eerld_checker (.*);
